FILE: rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed session table with expiry.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int DEPTH        = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int ENTRY_W      = 64 + 8 + 64 + PAYLOAD_BITS;

  localparam logic [2:0] ACT_ADD            = 3'd0;
  localparam logic [2:0] ACT_FIND           = 3'd1;
  localparam logic [2:0] ACT_REMOVE         = 3'd2;
  localparam logic [2:0] ACT_REMOVE_SESSION = 3'd3;
  localparam logic [2:0] ACT_CLEANUP        = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] session_id;
    logic [7:0]  context_req;
    logic [63:0] expiry_time;
    logic [63:0] entry_payload;
    logic [63:0] current_time;
  } kst_in_t;

  typedef struct packed {
    logic        success;
    logic [63:0] found_expiry;
    logic [63:0] found_payload;
    logic [5:0]  removed_count;
    logic [5:0]  entries_in_use;
  } kst_out_t;

  typedef struct packed {
    logic [63:0]             session;
    logic [7:0]              ctx;
    logic [63:0]             expiry;
    logic [PAYLOAD_BITS-1:0] payload;
  } kst_entry_t;

  typedef struct packed {
    logic key_hit;
    logic sess_hit;
    logic expired;
    logic free;
  } kst_hit_t;

endpackage

FILE: rtl/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/kst_match.sv
// ----------------------------------------------------------------------------
// kst_match
// Compares one stored entry against the request key and the present time.
// ----------------------------------------------------------------------------
module kst_match (
  input  kst_pkg::kst_in_t    req,
  input  kst_pkg::kst_entry_t entry,
  input  logic                valid,
  output kst_pkg::kst_hit_t   hit
);

  logic id_ok;
  logic sess_eq;

  assign id_ok   = (req.session_id != 64'd0);
  assign sess_eq = valid && id_ok && (entry.session == req.session_id);

  always_comb begin
    hit.sess_hit = sess_eq;
    hit.key_hit  = sess_eq && (entry.ctx == req.context_req);
    hit.expired  = valid && (entry.expiry != 64'd0) && (entry.expiry <= req.current_time);
    hit.free     = !valid;
  end

endmodule

FILE: rtl/keyed_session_table_with_expiry_top.sv
// ----------------------------------------------------------------------------
// keyed_session_table_with_expiry_top
// Session table: entries in one RAM, active flags in flops, one sequential
// scan of all slots per transaction.
// Slots are read in order through the single RAM read port; busy is high
// from accept until the out_valid strobe, and start is ignored meanwhile.
// Reset: synchronous; all slots inactive, in-use count zero, table ready.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module keyed_session_table_with_expiry_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kst_pkg::kst_in_t  in_data,
  output logic              out_valid,
  output kst_pkg::kst_out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  kst_pkg::kst_in_t               req_r, req_nxt;
  logic [kst_pkg::DEPTH-1:0]      valid_r, valid_nxt;
  logic [kst_pkg::CNT_W-1:0]      inuse_r, inuse_nxt;
  logic [kst_pkg::CNT_W-1:0]      removed_r, removed_nxt;
  logic [kst_pkg::CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [kst_pkg::IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                           hit_found_r, hit_found_nxt;
  logic [kst_pkg::IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic                           free_found_r, free_found_nxt;
  logic [kst_pkg::IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [63:0]                    fexp_r, fexp_nxt;
  logic [63:0]                    fpay_r, fpay_nxt;
  logic                           out_valid_r, out_valid_nxt;
  kst_pkg::kst_out_t              out_data_r, out_data_nxt;

  logic                           ram_we;
  logic [kst_pkg::IDX_W-1:0]      ram_waddr;
  kst_pkg::kst_entry_t            ram_wentry;
  logic                           ram_re;
  logic [kst_pkg::IDX_W-1:0]      ram_raddr;
  logic [kst_pkg::ENTRY_W-1:0]    ram_rdata;
  kst_pkg::kst_entry_t            rd_entry;
  kst_pkg::kst_hit_t              hit;
  logic                           slot_valid;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_entry  = kst_pkg::kst_entry_t'(ram_rdata);
  assign slot_valid = valid_r[cmp_idx_r];

  assign ram_re    = (state_r == ST_SCAN) && (rd_cnt_r < kst_pkg::CNT_W'(kst_pkg::DEPTH));
  assign ram_raddr = rd_cnt_r[kst_pkg::IDX_W-1:0];

  assign ram_wentry.session = req_r.session_id;
  assign ram_wentry.ctx     = req_r.context_req;
  assign ram_wentry.expiry  = req_r.expiry_time;
  assign ram_wentry.payload = req_r.entry_payload[kst_pkg::PAYLOAD_BITS-1:0];

  kst_ram #(
    .WIDTH (kst_pkg::ENTRY_W),
    .DEPTH (kst_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (kst_pkg::ENTRY_W'(ram_wentry)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kst_match u_match (
    .req   (req_r),
    .entry (rd_entry),
    .valid (slot_valid),
    .hit   (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    valid_nxt      = valid_r;
    inuse_nxt      = inuse_r;
    removed_nxt    = removed_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    fexp_nxt       = fexp_r;
    fpay_nxt       = fpay_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt        = in_data;
          rd_cnt_nxt     = '0;
          removed_nxt    = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          hit_idx_nxt    = '0;
          free_idx_nxt   = '0;
          fexp_nxt       = '0;
          fpay_nxt       = '0;
          state_nxt      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (ram_re) begin
          rd_cnt_nxt  = rd_cnt_r + kst_pkg::CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ram_raddr;
        end
        if (cmp_vld_r) begin
          case (req_r.action)
            kst_pkg::ACT_ADD: begin
              if (hit.key_hit && !hit_found_r) begin
                hit_found_nxt = 1'b1;
                hit_idx_nxt   = cmp_idx_r;
              end
              if (hit.free && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = cmp_idx_r;
              end
            end
            kst_pkg::ACT_FIND: begin
              if (hit.key_hit && !hit_found_r) begin
                hit_found_nxt = 1'b1;
                fexp_nxt      = rd_entry.expiry;
                fpay_nxt      = 64'(rd_entry.payload);
              end
            end
            kst_pkg::ACT_REMOVE: begin
              if (hit.key_hit && !hit_found_r) begin
                hit_found_nxt         = 1'b1;
                valid_nxt[cmp_idx_r]  = 1'b0;
                removed_nxt           = removed_r + kst_pkg::CNT_W'(1);
                inuse_nxt             = inuse_r - kst_pkg::CNT_W'(1);
              end
            end
            kst_pkg::ACT_REMOVE_SESSION: begin
              if (hit.sess_hit) begin
                valid_nxt[cmp_idx_r] = 1'b0;
                removed_nxt          = removed_r + kst_pkg::CNT_W'(1);
                inuse_nxt            = inuse_r - kst_pkg::CNT_W'(1);
              end
            end
            kst_pkg::ACT_CLEANUP: begin
              if (hit.expired) begin
                valid_nxt[cmp_idx_r] = 1'b0;
                removed_nxt          = removed_r + kst_pkg::CNT_W'(1);
                inuse_nxt            = inuse_r - kst_pkg::CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          if (cmp_idx_r == kst_pkg::IDX_W'(kst_pkg::DEPTH - 1)) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        out_data_nxt.success       = 1'b0;
        out_data_nxt.found_expiry  = 64'd0;
        out_data_nxt.found_payload = 64'd0;
        if (req_r.action == kst_pkg::ACT_ADD) begin
          if (hit_found_r) begin
            ram_we                = 1'b1;
            ram_waddr             = hit_idx_r;
            out_data_nxt.success  = 1'b1;
          end else if (free_found_r && (req_r.session_id != 64'd0)) begin
            ram_we                = 1'b1;
            ram_waddr             = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
            inuse_nxt             = inuse_r + kst_pkg::CNT_W'(1);
            out_data_nxt.success  = 1'b1;
          end
        end else if (req_r.action == kst_pkg::ACT_FIND) begin
          out_data_nxt.success       = hit_found_r;
          out_data_nxt.found_expiry  = fexp_r;
          out_data_nxt.found_payload = fpay_r;
        end
        out_data_nxt.removed_count  = 6'(removed_r);
        out_data_nxt.entries_in_use = 6'(inuse_nxt);
        out_valid_nxt               = 1'b1;
        state_nxt                   = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      inuse_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      inuse_r     <= inuse_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    removed_r    <= removed_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    fexp_r       <= fexp_nxt;
    fpay_r       <= fpay_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
